// ===== hdl/linear_probe_hash_table_defines.svh =====
// assertion macros for the linear probe hash table
// used by the top level; expects clk and rst_n in the including scope
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication, idle during reset
`define LPHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, idle during reset
`define LPHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/lpht_pkg.sv =====
// shared codes and field widths for the linear probe hash table
// no dependencies
package lpht_pkg;

  localparam int MODE_W       = 2;
  localparam int KEY_W        = 32;
  localparam int HASH_W       = 32;
  localparam int VALUE_W      = 32;
  localparam int STATUS_W     = 2;
  localparam int ITEM_COUNT_W = 11;

  // request modes; the unused code behaves as a lookup
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] RS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] RS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] RS_FULL      = 2'd2;

  // slot occupancy
  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_LIVE  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

endpackage

// ===== hdl/lpht_req_if.sv =====
// request channel of the hash table: valid/ready plus request fields
// depends on lpht_pkg
interface lpht_req_if;
  import lpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [KEY_W-1:0]    key;
  logic [HASH_W-1:0]   key_hash;
  logic [VALUE_W-1:0]  value;

  modport source (output valid, mode, key, key_hash, value, input ready);
  modport sink   (input valid, mode, key, key_hash, value, output ready);
endinterface

// ===== hdl/lpht_rsp_if.sv =====
// result channel of the hash table: valid/ready plus result fields
// depends on lpht_pkg
interface lpht_rsp_if;
  import lpht_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [VALUE_W-1:0]      found_value;
  logic [ITEM_COUNT_W-1:0] item_count;

  modport source (output valid, status, found_value, item_count, input ready);
  modport sink   (input valid, status, found_value, item_count, output ready);
endinterface

// ===== hdl/lpht_slot_ram.sv =====
// slot memory: one write port, one read port, registered read data
// no dependencies
module lpht_slot_ram #(
  parameter int AW = 11,
  parameter int DW = 76
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/linear_probe_hash_table.sv =====
// open-addressing hash table with linear probing, tombstones and resizing
// depends on lpht_pkg, lpht_req_if, lpht_rsp_if, lpht_slot_ram and the defines header
//
// One request at a time: the block takes a request only when idle and holds the
// result in an output register until it is taken. Slots live in one memory of two
// banks; the current table sits in one bank and a resize rebuilds into the other,
// flipping banks only when every live entry has been placed, so a failed rehash
// leaves the old table untouched. Each slot probe is a read state and a check
// state, so a lookup or update passes through the idle state that takes the
// request, the probes and the result state. An insert of a new key or a remove of
// a present key adds a load check state, and a new key is then probed again for a
// free place. When the load test fires a resize clears every slot of the target
// bank, scans each old slot and probes the new table to place each live entry. No
// clearing pass runs after reset: the first insert or remove marks slot 0 empty
// and every larger table is cleared by its own resize.
module linear_probe_hash_table #(
  parameter int MAX_SLOTS  = 1024,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lpht_req_if.sink   in_req,
  lpht_rsp_if.source out_rsp
);
  import lpht_pkg::*;

  // slot index, count and size-log widths
  localparam int AW  = $clog2(MAX_SLOTS);
  localparam int CW  = $clog2(MAX_SLOTS + 1);
  localparam int SLW = $clog2(AW + 1);
  // stored key and value widths: only the low bits take part
  localparam int KW  = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int VW  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  // slot word: status, key, value, low hash bits
  localparam int DW  = 2 + KW + VW + AW;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_FIND_RD  = 12'b0000_0000_0010,
    S_FIND_CHK = 12'b0000_0000_0100,
    S_LOAD     = 12'b0000_0000_1000,
    S_CLR      = 12'b0000_0001_0000,
    S_RH_RD    = 12'b0000_0010_0000,
    S_RH_CHK   = 12'b0000_0100_0000,
    S_PL_RD    = 12'b0000_1000_0000,
    S_PL_CHK   = 12'b0001_0000_0000,
    S_INS_RD   = 12'b0010_0000_0000,
    S_INS_CHK  = 12'b0100_0000_0000,
    S_RESP     = 12'b1000_0000_0000
  } state_t;

  function automatic logic [AW-1:0] mask_of(input logic [SLW-1:0] l);
    mask_of = ~({AW{1'b1}} << l);
  endfunction

  function automatic logic [AW:0] size_of(input logic [SLW-1:0] l);
    size_of = {{AW{1'b0}}, 1'b1} << l;
  endfunction

  // control state
  state_t              state_r, state_nxt;
  logic                alloc_r, alloc_nxt;     // table allocated
  logic                bank_r, bank_nxt;       // bank holding the live table
  logic [SLW-1:0]      slog_r, slog_nxt;       // log2 of current size
  logic [CW-1:0]       live_r, live_nxt;       // live entries

  // request and working registers
  logic [SLW-1:0]      nlog_r, nlog_nxt;       // log2 of resize target
  logic [CW-1:0]       items_r, items_nxt;     // count fed to the load test
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [AW-1:0]       hash_r, hash_nxt;
  logic [VW-1:0]       val_r, val_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [VALUE_W-1:0]  found_r, found_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;         // slot being probed
  logic [AW:0]         k_r, k_nxt;             // probes done
  logic [AW:0]         i_r, i_nxt;             // sweep / old-table scan index
  logic [DW-1:0]       ent_r, ent_nxt;         // entry being moved by a rehash

  // memory ports
  logic                mem_we;
  logic [AW:0]         mem_waddr;
  logic [DW-1:0]       mem_wdata;
  logic [AW:0]         mem_raddr;
  logic [DW-1:0]       rd_data;

  // read word fields
  slot_st_t            rd_st;
  logic [KW-1:0]       rd_key;
  logic [VW-1:0]       rd_val;
  logic [AW-1:0]       rd_hash;

  // derived values
  logic [AW-1:0]       cur_mask, new_mask;
  logic [AW:0]         cur_size, new_size;
  logic                is_ins, is_rem, in_is_upd;
  logic                k_last, k_last_new, scan_last, clr_last;
  logic [CW+1:0]       items4, thr3, thr2;
  logic                grow, shrink, grow_ok;
  logic [CW-1:0]       live_dec;

  assign rd_st   = slot_st_t'(rd_data[DW-1 -: 2]);
  assign rd_key  = rd_data[DW-3 -: KW];
  assign rd_val  = rd_data[AW +: VW];
  assign rd_hash = rd_data[AW-1:0];

  assign cur_mask = mask_of(slog_r);
  assign new_mask = mask_of(nlog_r);
  assign cur_size = size_of(slog_r);
  assign new_size = size_of(nlog_r);

  assign is_ins    = (mode_r == MODE_INSERT);
  assign is_rem    = (mode_r == MODE_REMOVE);
  assign in_is_upd = (in_req.mode == MODE_INSERT) || (in_req.mode == MODE_REMOVE);

  assign k_last     = (k_r + (AW+1)'(1)) == cur_size;
  assign k_last_new = (k_r + (AW+1)'(1)) == new_size;
  assign scan_last  = (i_r + (AW+1)'(1)) == cur_size;
  assign clr_last   = (i_r + (AW+1)'(1)) == new_size;

  // load test items*4/size against 3 and 1, size a power of two
  assign items4 = {items_r, 2'b00};
  assign thr3   = (CW+2)'(3) << slog_r;
  assign thr2   = (CW+2)'(2) << slog_r;
  assign grow   = (items4 >= thr3);
  assign shrink = (items4 < thr2);
  // doubled size still within the slot limit
  assign grow_ok = ({cur_size, 1'b0} <= (AW+2)'(MAX_SLOTS));

  assign live_dec = (live_r != '0) ? (live_r - CW'(1)) : live_r;

  // handshakes: take a request only when idle, show the result register
  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = (state_r == S_RESP);
  assign out_rsp.status      = status_r;
  assign out_rsp.found_value = found_r;
  assign out_rsp.item_count  = ITEM_COUNT_W'(live_r);

  lpht_slot_ram #(
    .AW (AW + 1),
    .DW (DW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt  = state_r;
    alloc_nxt  = alloc_r;
    bank_nxt   = bank_r;
    slog_nxt   = slog_r;
    live_nxt   = live_r;
    nlog_nxt   = nlog_r;
    items_nxt  = items_r;
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    hash_nxt   = hash_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    found_nxt  = found_r;
    idx_nxt    = idx_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    ent_nxt    = ent_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_raddr  = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          mode_nxt   = in_req.mode;
          key_nxt    = KW'(in_req.key);
          hash_nxt   = in_req.key_hash[AW-1:0];
          val_nxt    = VW'(in_req.value);
          status_nxt = RS_OK;
          found_nxt  = '0;
          k_nxt      = '0;
          if (alloc_r) begin
            idx_nxt   = in_req.key_hash[AW-1:0] & cur_mask;
            state_nxt = S_FIND_RD;
          end else if (in_is_upd) begin
            // first insert or remove: one-slot table, slot 0 marked empty
            alloc_nxt = 1'b1;
            slog_nxt  = '0;
            live_nxt  = '0;
            idx_nxt   = '0;
            mem_we    = 1'b1;
            mem_waddr = {bank_r, {AW{1'b0}}};
            mem_wdata = {ST_EMPTY, {(DW-2){1'b0}}};
            state_nxt = S_FIND_RD;
          end else begin
            status_nxt = RS_NOT_FOUND;
            state_nxt  = S_RESP;
          end
        end
      end

      S_FIND_RD: begin
        mem_raddr = {bank_r, idx_r};
        state_nxt = S_FIND_CHK;
      end

      S_FIND_CHK: begin
        if (rd_st == ST_LIVE && rd_key == key_r) begin
          if (is_ins) begin
            mem_we    = 1'b1;
            mem_waddr = {bank_r, idx_r};
            mem_wdata = {ST_LIVE, rd_key, val_r, rd_hash};
            state_nxt = S_RESP;
          end else if (is_rem) begin
            mem_we    = 1'b1;
            mem_waddr = {bank_r, idx_r};
            mem_wdata = {ST_TOMB, rd_key, rd_val, rd_hash};
            live_nxt  = live_dec;
            items_nxt = live_dec;
            state_nxt = S_LOAD;
          end else begin
            found_nxt = VALUE_W'(rd_val);
            state_nxt = S_RESP;
          end
        end else if (rd_st == ST_EMPTY || k_last) begin
          if (is_ins) begin
            items_nxt = live_r + CW'(1);
            state_nxt = S_LOAD;
          end else begin
            status_nxt = RS_NOT_FOUND;
            state_nxt  = S_RESP;
          end
        end else begin
          idx_nxt   = (idx_r + AW'(1)) & cur_mask;
          k_nxt     = k_r + (AW+1)'(1);
          state_nxt = S_FIND_RD;
        end
      end

      S_LOAD: begin
        if (grow && grow_ok) begin
          nlog_nxt  = slog_r + SLW'(1);
          i_nxt     = '0;
          state_nxt = S_CLR;
        end else if (!grow && shrink && slog_r != '0) begin
          nlog_nxt  = slog_r - SLW'(1);
          i_nxt     = '0;
          state_nxt = S_CLR;
        end else if (grow || shrink) begin
          // growth past the limit or shrink below one slot
          status_nxt = RS_FULL;
          state_nxt  = S_RESP;
        end else if (is_ins) begin
          idx_nxt   = hash_r & cur_mask;
          k_nxt     = '0;
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end

      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = {~bank_r, i_r[AW-1:0]};
        mem_wdata = {ST_EMPTY, {(DW-2){1'b0}}};
        if (clr_last) begin
          i_nxt     = '0;
          state_nxt = S_RH_RD;
        end else begin
          i_nxt = i_r + (AW+1)'(1);
        end
      end

      S_RH_RD: begin
        mem_raddr = {bank_r, i_r[AW-1:0]};
        state_nxt = S_RH_CHK;
      end

      S_RH_CHK: begin
        ent_nxt = rd_data;
        if (rd_st == ST_LIVE) begin
          idx_nxt   = rd_hash & new_mask;
          k_nxt     = '0;
          state_nxt = S_PL_RD;
        end else if (!scan_last) begin
          i_nxt     = i_r + (AW+1)'(1);
          state_nxt = S_RH_RD;
        end else begin
          // rehash done: switch to the new bank
          bank_nxt = ~bank_r;
          slog_nxt = nlog_r;
          if (is_ins) begin
            idx_nxt   = hash_r & new_mask;
            k_nxt     = '0;
            state_nxt = S_INS_RD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end

      S_PL_RD: begin
        mem_raddr = {~bank_r, idx_r};
        state_nxt = S_PL_CHK;
      end

      S_PL_CHK: begin
        if (rd_st == ST_EMPTY) begin
          mem_we    = 1'b1;
          mem_waddr = {~bank_r, idx_r};
          mem_wdata = ent_r;
          if (!scan_last) begin
            i_nxt     = i_r + (AW+1)'(1);
            state_nxt = S_RH_RD;
          end else begin
            bank_nxt = ~bank_r;
            slog_nxt = nlog_r;
            if (is_ins) begin
              idx_nxt   = hash_r & new_mask;
              k_nxt     = '0;
              state_nxt = S_INS_RD;
            end else begin
              state_nxt = S_RESP;
            end
          end
        end else if (k_last_new) begin
          // no room in the new table: old table stays
          status_nxt = RS_FULL;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt   = (idx_r + AW'(1)) & new_mask;
          k_nxt     = k_r + (AW+1)'(1);
          state_nxt = S_PL_RD;
        end
      end

      S_INS_RD: begin
        mem_raddr = {bank_r, idx_r};
        state_nxt = S_INS_CHK;
      end

      S_INS_CHK: begin
        if (rd_st != ST_LIVE) begin
          // empty or tombstone slot takes the new key
          mem_we    = 1'b1;
          mem_waddr = {bank_r, idx_r};
          mem_wdata = {ST_LIVE, key_r, val_r, hash_r};
          live_nxt  = live_r + CW'(1);
          state_nxt = S_RESP;
        end else if (k_last) begin
          status_nxt = RS_FULL;
          state_nxt  = S_RESP;
        end else begin
          idx_nxt   = (idx_r + AW'(1)) & cur_mask;
          k_nxt     = k_r + (AW+1)'(1);
          state_nxt = S_INS_RD;
        end
      end

      S_RESP: begin
        if (out_rsp.ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      alloc_r <= 1'b0;
      bank_r  <= 1'b0;
      slog_r  <= '0;
      live_r  <= '0;
    end else begin
      state_r <= state_nxt;
      alloc_r <= alloc_nxt;
      bank_r  <= bank_nxt;
      slog_r  <= slog_nxt;
      live_r  <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nlog_r   <= nlog_nxt;
    items_r  <= items_nxt;
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    hash_r   <= hash_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    found_r  <= found_nxt;
    idx_r    <= idx_nxt;
    k_r      <= k_nxt;
    i_r      <= i_nxt;
    ent_r    <= ent_nxt;
  end

  `include "linear_probe_hash_table_defines.svh"

  // a result on show never overlaps taking a request
  `LPHT_ASSERT_IMP(a_resp_blocks_req, out_rsp.valid, !in_req.ready,
                   "request taken while result pending")
  // live entries always fit the allocated table
  `LPHT_ASSERT_IMP(a_live_fits, alloc_r, live_r <= cur_size,
                   "live count exceeds table size")
  // banks switch only at the end of a rehash
  `LPHT_ASSERT_NEXT(a_bank_flip, (state_r != S_RH_CHK) && (state_r != S_PL_CHK),
                    bank_r == $past(bank_r), "bank switched outside rehash")

endmodule

// ===== bench/lpht_checker.sv =====
// request/result checker for the linear probe hash table: predicts every result
// depends on lpht_pkg, lpht_req_if and lpht_rsp_if
module lpht_checker #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic  clk,
  input  logic  rst_n,
  lpht_req_if   req,
  lpht_rsp_if   rsp,
  output int    fail_count,
  output int    pending,
  output int    seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [VALUE_W-1:0]      found_value;
    logic [ITEM_COUNT_W-1:0] item_count;
  } rsp_t;

  rsp_t queue_of_answers[$];

  slot_st_t          tbl_st  [MAX_SLOTS];
  logic [KEY_W-1:0]  tbl_key [MAX_SLOTS];
  logic [VALUE_W-1:0] tbl_val[MAX_SLOTS];
  logic [HASH_W-1:0] tbl_hash[MAX_SLOTS];
  slot_st_t          nx_st   [MAX_SLOTS];
  logic [KEY_W-1:0]  nx_key  [MAX_SLOTS];
  logic [VALUE_W-1:0] nx_val [MAX_SLOTS];
  logic [HASH_W-1:0] nx_hash [MAX_SLOTS];
  int  tbl_log;
  bit  tbl_alloc;
  int  live;

  function automatic int tbl_size();
    return tbl_alloc ? (1 << tbl_log) : 0;
  endfunction

  function automatic bit find_slot(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h, output int at);
    int n;
    int i;
    n  = tbl_size();
    at = 0;
    if (n == 0) return 0;
    for (int s = 0; s < n; s++) begin
      i = (int'(h & (n - 1)) + s) & (n - 1);
      if (tbl_st[i] == ST_EMPTY) return 0;
      if (tbl_st[i] == ST_LIVE && tbl_key[i] == k) begin
        at = i;
        return 1;
      end
    end
    return 0;
  endfunction

  // load test and rehash; returns 0 when the resize cannot be done
  function automatic bit rebalance(int items);
    int n;
    int nn;
    int nl;
    int fill;
    int j;
    bit placed;
    n = tbl_size();
    if (n == 0) return 0;
    fill = (items * 4) / n;
    if (fill >= 3) begin
      nn = n << 1;
      nl = tbl_log + 1;
    end else if (fill <= 1) begin
      if (tbl_log == 0) return 0;
      nn = n >> 1;
      nl = tbl_log - 1;
    end else begin
      return 1;
    end
    if (nn > MAX_SLOTS) return 0;
    for (int i = 0; i < MAX_SLOTS; i++) nx_st[i] = ST_EMPTY;
    for (int i = 0; i < n; i++) begin
      if (tbl_st[i] == ST_LIVE) begin
        placed = 0;
        for (int s = 0; s < nn && !placed; s++) begin
          j = (int'(tbl_hash[i] & (nn - 1)) + s) & (nn - 1);
          if (nx_st[j] == ST_EMPTY) begin
            nx_st[j]   = ST_LIVE;
            nx_key[j]  = tbl_key[i];
            nx_val[j]  = tbl_val[i];
            nx_hash[j] = tbl_hash[i];
            placed = 1;
          end
        end
        if (!placed) return 0;
      end
    end
    for (int i = 0; i < nn; i++) begin
      tbl_st[i]   = nx_st[i];
      tbl_key[i]  = nx_key[i];
      tbl_val[i]  = nx_val[i];
      tbl_hash[i] = nx_hash[i];
    end
    tbl_log = nl;
    return 1;
  endfunction

  function automatic void alloc_if_needed();
    if (!tbl_alloc) begin
      tbl_alloc = 1;
      tbl_log   = 0;
      live      = 0;
      tbl_st[0] = ST_EMPTY;
    end
  endfunction

  function automatic rsp_t apply_request(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                                         logic [HASH_W-1:0] h, logic [VALUE_W-1:0] v);
    rsp_t r;
    int at;
    int n;
    int i;
    bit ok;
    r = '0;
    r.status = RS_OK;
    if (m == MODE_INSERT) begin
      alloc_if_needed();
      if (find_slot(k, h, at)) begin
        tbl_val[at] = v;
      end else if (!rebalance(live + 1)) begin
        r.status = RS_FULL;
      end else begin
        n  = tbl_size();
        ok = 0;
        for (int s = 0; s < n && !ok; s++) begin
          i = (int'(h & (n - 1)) + s) & (n - 1);
          if (tbl_st[i] != ST_LIVE) begin
            tbl_st[i]   = ST_LIVE;
            tbl_key[i]  = k;
            tbl_val[i]  = v;
            tbl_hash[i] = h;
            live++;
            ok = 1;
          end
        end
        if (!ok) r.status = RS_FULL;
      end
    end else if (m == MODE_REMOVE) begin
      alloc_if_needed();
      if (!find_slot(k, h, at)) begin
        r.status = RS_NOT_FOUND;
      end else begin
        tbl_st[at] = ST_TOMB;
        if (live > 0) live--;
        if (!rebalance(live)) r.status = RS_FULL;
      end
    end else begin
      // lookup, and the unused mode code behaves the same
      if (find_slot(k, h, at)) r.found_value = tbl_val[at];
      else r.status = RS_NOT_FOUND;
    end
    r.item_count = live[ITEM_COUNT_W-1:0];
    return r;
  endfunction

  initial begin
    for (int i = 0; i < MAX_SLOTS; i++) tbl_st[i] = ST_EMPTY;
    tbl_log    = 0;
    tbl_alloc  = 0;
    live       = 0;
    fail_count = 0;
    seen       = 0;
  end

  assign pending = queue_of_answers.size();

  always @(posedge clk) begin
    rsp_t got;
    rsp_t want;
    if (rst_n) begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.found_value, rsp.item_count};
        seen <= seen + 1;
        if (queue_of_answers.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10) $display("unexpected result %p", got);
        end else begin
          want = queue_of_answers.pop_front();
          if (got.status !== want.status || got.found_value !== want.found_value ||
              got.item_count !== want.item_count) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10)
              $display("mismatch: status %0d/%0d value %h/%h count %0d/%0d (exp/act)",
                       want.status, got.status, want.found_value, got.found_value,
                       want.item_count, got.item_count);
          end
        end
      end
      if (req.valid && req.ready)
        queue_of_answers.push_back(apply_request(req.mode, req.key, req.key_hash, req.value));
    end
  end
endmodule

// ===== bench/linear_probe_hash_table_test.sv =====
// top of the hash table bench: clock, reset, request and result drivers, verdict
// depends on lpht_pkg, both channel interfaces, lpht_checker and the block itself
module linear_probe_hash_table_test;
  import lpht_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 40000;  // cycles with no transfer before giving up

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   seen;
  int   sent;
  int   idle_cycles;
  bit   no_gaps;       // stretches where neither side idles
  bit   stim_done;
  logic [KEY_W-1:0]  grow_keys[$];
  logic [HASH_W-1:0] grow_hashes[$];

  lpht_req_if in_req();
  lpht_rsp_if out_rsp();

  linear_probe_hash_table dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  lpht_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (in_req),
    .rsp        (out_rsp),
    .fail_count (fail_count),
    .pending    (pending),
    .seen       (seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // fixed hash per pool key so repeated keys probe the same chain
  function automatic logic [HASH_W-1:0] pool_hash(logic [KEY_W-1:0] k);
    return (k * 32'h9E37_79B1) ^ (k >> 3);
  endfunction

  // one request: optional idle gap, then hold valid until the block takes it
  task automatic send_request(logic [MODE_W-1:0] m, logic [KEY_W-1:0] k,
                              logic [HASH_W-1:0] h, logic [VALUE_W-1:0] v);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_req.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req.mode     = m;
    in_req.key      = k;
    in_req.key_hash = h;
    in_req.value    = v;
    in_req.valid    = 1'b1;
    do @(posedge clk); while (!in_req.ready);
    sent++;
    @(negedge clk);
  endtask

  // result side: random stalls, plus one long hold-off so the block backs up
  initial begin
    int gap;
    out_rsp.ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (seen == 150) begin
        out_rsp.ready = 1'b0;
        repeat (500) @(negedge clk);
      end
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_rsp.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_rsp.ready = 1'b1;
      do @(posedge clk); while (!out_rsp.valid);
      @(negedge clk);
    end
  end

  // watchdog on transfers in either direction
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) || !rst_n)
        idle_cycles = 0;
      else if (!stim_done || pending != 0)
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0] k;
    logic [MODE_W-1:0] m;
    int pick;
    rst_n         = 1'b0;
    in_req.valid  = 1'b0;
    in_req.mode   = MODE_LOOKUP;
    in_req.key    = '0;
    in_req.key_hash = '0;
    in_req.value  = '0;
    no_gaps       = 1'b0;
    stim_done     = 1'b0;
    sent          = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty table, extremes, update, odd mode, absent remove, collisions, shrink
    send_request(MODE_LOOKUP, 32'h0, 32'h0, 32'h0);                    // unallocated
    send_request(MODE_REMOVE, 32'h5, 32'h5, 32'h0);                    // allocates one slot
    send_request(MODE_INSERT, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);    // grows
    send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(MODE_INSERT, 32'h0, 32'h0, 32'h1234_5678);            // update
    send_request(MODE_LOOKUP, 32'h0, 32'h0, 32'h0);
    send_request(MODE_SPARE, 32'h0, 32'h0, 32'hFFFF_FFFF);             // unused mode
    send_request(MODE_INSERT, 32'hA5A5_A5A5, 32'h0, 32'h5A5A_5A5A);    // same start slot
    send_request(MODE_INSERT, 32'h5A5A_5A5A, 32'h0, 32'hA5A5_A5A5);
    send_request(MODE_INSERT, 32'h0F0F_0F0F, 32'h4, 32'hF0F0_F0F0);
    send_request(MODE_LOOKUP, 32'h5A5A_5A5A, 32'h0, 32'h0);
    send_request(MODE_REMOVE, 32'h1111_1111, 32'h0, 32'h0);            // absent key
    send_request(MODE_REMOVE, 32'hA5A5_A5A5, 32'h0, 32'h0);
    send_request(MODE_LOOKUP, 32'h5A5A_5A5A, 32'h0, 32'h0);            // past tombstone
    send_request(MODE_REMOVE, 32'h5A5A_5A5A, 32'h0, 32'h0);            // shrinks
    send_request(MODE_REMOVE, 32'h0F0F_0F0F, 32'h4, 32'h0);
    send_request(MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(MODE_REMOVE, 32'h0, 32'h0, 32'h0);                    // back to one slot
    send_request(MODE_LOOKUP, 32'h0, 32'h0, 32'h0);

    // random mix over a small key pool, with the odd random key and hash
    for (int i = 0; i < 320; i++) begin
      if (i % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, 47);
      m = (pick < 4) ? MODE_INSERT :
          (pick < 6) ? MODE_REMOVE :
          (pick < 9) ? MODE_LOOKUP : MODE_SPARE;
      if ($urandom_range(0, 15) == 0)
        send_request(m, $urandom, $urandom, $urandom);
      else
        send_request(m, k, pool_hash(k), $urandom);
    end
    no_gaps = 1'b0;

    // fill to the largest table and past it, so growth fails
    for (int i = 0; i < 780; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      grow_keys.push_back(32'h8000_0000 | i);
      grow_hashes.push_back($urandom);
      send_request(MODE_INSERT, grow_keys[i], grow_hashes[i], $urandom);
    end

    // drain again: removes, lookups and re-inserts of the grown set
    for (int i = 0; i < 200; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 779);
      case ($urandom_range(0, 3)) inside
        0, 1: m = MODE_REMOVE;
        2: m = MODE_LOOKUP;
        default: m = MODE_INSERT;
      endcase
      send_request(m, grow_keys[pick], grow_hashes[pick], $urandom);
    end
    in_req.valid = 1'b0;
    stim_done = 1'b1;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("%0d requests sent, %0d results checked: empty, growth to full size,", sent, seen);
    $display("failed growth, collisions, tombstones and shrinking exercised");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
